/* rtl/core/ultrasonic_echo_ranger_core_macros.svh */
// assertion macros for the ultrasonic echo ranger checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

// property checked only while out of reset
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/uer_pkg.sv */
// shared types and constants for the ultrasonic echo ranger
// no dependencies
`default_nettype none

package uer_pkg;

  typedef enum logic [4:0] {
    PH_TRIG   = 5'b00001,
    PH_RISE   = 5'b00010,
    PH_MEAS   = 5'b00100,
    PH_REPORT = 5'b01000,
    PH_GAP    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    REG_TRIGGER_WIDTH = 2'd0,
    REG_RISE_TIMEOUT  = 2'd1,
    REG_ECHO_TIMEOUT  = 2'd2,
    REG_REPEAT_GAP    = 2'd3
  } cfg_reg_e;

  localparam int unsigned TrigW   = 8;
  localparam int unsigned TmoW    = 16;
  localparam int unsigned GapW    = 18;
  localparam int unsigned TicksW  = 18;
  localparam int unsigned DistW   = 11;
  localparam int unsigned CfgDataW = 18;

  localparam logic [TrigW-1:0] TrigWidthRst = 8'd10;
  localparam logic [TmoW-1:0]  RiseTmoRst   = 16'd10000;
  localparam logic [TmoW-1:0]  EchoTmoRst   = 16'd50000;
  localparam logic [GapW-1:0]  RepeatGapRst = 18'd200000;

  // width * 17 fits 21 bits; divide by 1000 as multiply by ceil(2^31/1000)
  localparam int unsigned ProdW    = 21;
  localparam int unsigned RecipW   = 22;
  localparam int unsigned RecipSh  = 31;
  localparam logic [RecipW-1:0] Recip1000 = 22'd2147484;

endpackage

`default_nettype wire

/* rtl/core/uer_dist.sv */
// distance conversion: floor(width * 17 / 1000) in cm
// depends on uer_pkg
`default_nettype none

module uer_dist
  import uer_pkg::*;
(
  input  wire logic [TmoW-1:0]  width_i,
  output logic      [DistW-1:0] dist_o
);

  logic [ProdW-1:0]                 scaled;
  logic [ProdW+RecipW-1:0]          prod;

  // times 17 as shift and add
  assign scaled = {1'b0, width_i, 4'b0000} + {5'b00000, width_i};
  assign prod   = (ProdW+RecipW)'(scaled) * (ProdW+RecipW)'(Recip1000);
  assign dist_o = prod[RecipSh+DistW-1:RecipSh];

endmodule

`default_nettype wire

/* rtl/core/ultrasonic_echo_ranger_core.sv */
// ultrasonic echo ranger: trigger, echo timing and distance report per tick
// depends on uer_pkg and uer_dist
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one microsecond tick with
//   the sampled echo pin level. Every accepted tick gives exactly one result
//   on the output channel (out_valid_o / out_stall_i): trigger pin drive, LED
//   drive, a report flag and the distance in cm (zero when not reported).
//   The result appears in the cycle after the input transfer; one tick can be
//   taken every cycle while the output is not stalled, bounded by the single
//   state update and the distance multiply between the state and the result register.
//   While the receiver stalls a finished result, the result register holds
//   and in_stall_o is raised, so no tick is taken until the result moves.
//   Configuration (cfg_valid_i, cfg_index_i, cfg_data_i) is always ready;
//   write it only while no tick is in flight.
//   Reset loads the default registers, puts the controller in the gap phase
//   with zero ticks left so the first tick starts a trigger, clears the LED
//   and clears out_valid_o; the report flag and distance are not reset.
`default_nettype none

module ultrasonic_echo_ranger_core
  import uer_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // tick input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                echo_level_i,
  // result output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     trigger_level_o,
  output logic                     led_on_o,
  output logic                     result_valid_o,
  output logic [DistW-1:0]         distance_cm_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CapW = (WIDTH_BITS > TmoW) ? WIDTH_BITS : TmoW;
  localparam logic [CapW-1:0] WidthMax = CapW'((64'd1 << WIDTH_BITS) - 64'd1);

  logic [TrigW-1:0] trig_width_q;
  logic [TmoW-1:0]  rise_tmo_q;
  logic [TmoW-1:0]  echo_tmo_q;
  logic [GapW-1:0]  repeat_gap_q;

  phase_e                phase_q, phase_d;
  logic [TicksW-1:0]     ticks_q, ticks_d;
  logic [WIDTH_BITS-1:0] width_q, width_d;
  logic                  led_q, led_d;

  logic             out_valid_q, out_valid_d;
  logic             res_valid_q, res_valid_d;
  logic [DistW-1:0] dist_q, dist_d;

  logic             accept;
  logic [CapW-1:0]  cap;
  logic [CapW-1:0]  width_ext;
  logic [TmoW-1:0]  width_clamp;
  logic [DistW-1:0] dist_calc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q <= TrigWidthRst;
      rise_tmo_q   <= RiseTmoRst;
      echo_tmo_q   <= EchoTmoRst;
      repeat_gap_q <= RepeatGapRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TRIGGER_WIDTH: trig_width_q <= cfg_data_i[TrigW-1:0];
        REG_RISE_TIMEOUT:  rise_tmo_q   <= cfg_data_i[TmoW-1:0];
        REG_ECHO_TIMEOUT:  echo_tmo_q   <= cfg_data_i[TmoW-1:0];
        REG_REPEAT_GAP:    repeat_gap_q <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  // width limit: echo timeout, bounded by the width counter size
  assign cap         = (CapW'(echo_tmo_q) < WidthMax) ? CapW'(echo_tmo_q) : WidthMax;
  assign width_ext   = CapW'(width_q);
  assign width_clamp = (width_ext > cap) ? cap[TmoW-1:0] : width_ext[TmoW-1:0];

  uer_dist u_dist (
    .width_i (width_clamp),
    .dist_o  (dist_calc)
  );

  always_comb begin
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    width_d     = width_q;
    led_d       = led_q;
    res_valid_d = 1'b0;
    dist_d      = '0;
    unique case (phase_q)
      PH_TRIG: begin
        if (ticks_q >= TicksW'(trig_width_q)) begin
          phase_d = PH_RISE;
          ticks_d = '0;
          led_d   = 1'b1;
        end else begin
          ticks_d = ticks_q + 1'b1;
        end
      end
      PH_RISE: begin
        if (echo_level_i) begin
          phase_d = PH_MEAS;
          width_d = WIDTH_BITS'(1);
          ticks_d = '0;
        end else if (ticks_q >= TicksW'(rise_tmo_q)) begin
          phase_d = PH_REPORT;
          width_d = '0;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_q + 1'b1;
        end
      end
      PH_MEAS: begin
        if (echo_level_i && (width_ext < cap)) begin
          width_d = width_q + 1'b1;
        end else begin
          phase_d = PH_REPORT;
        end
      end
      PH_REPORT: begin
        if (dist_calc != '0) begin
          res_valid_d = 1'b1;
          dist_d      = dist_calc;
          led_d       = 1'b0;
        end
        phase_d = PH_GAP;
        ticks_d = TicksW'(repeat_gap_q);
      end
      PH_GAP: begin
        if (ticks_q == '0) begin
          phase_d = PH_TRIG;
          ticks_d = TicksW'(1);
        end else begin
          ticks_d = ticks_q - 1'b1;
        end
      end
      default: begin
        phase_d = PH_GAP;
        ticks_d = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_GAP;
      ticks_q     <= '0;
      width_q     <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        ticks_q <= ticks_d;
        width_q <= width_d;
        led_q   <= led_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_valid_q <= res_valid_d;
      dist_q      <= dist_d;
    end
  end

  // trigger and led follow the state, which only moves on a transfer
  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = (phase_q == PH_TRIG);
  assign led_on_o        = led_q;
  assign result_valid_o  = res_valid_q;
  assign distance_cm_o   = dist_q;

endmodule

`default_nettype wire

/* rtl/core/uer_checker.sv */
// port-level checks for the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger_core_macros.svh
`default_nettype none

`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_checker
  import uer_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             trigger_level_o,
  input wire logic             led_on_o,
  input wire logic             result_valid_o,
  input wire logic [DistW-1:0] distance_cm_o,
  input wire logic             cfg_ready_o
);

  // every tick transfer yields a result on the next cycle
  `UER_ASSERT(a_tick_gives_result, in_valid_i && !in_stall_o |=> out_valid_o,
              "tick without result")

  // a report carries a nonzero distance, turns the led off and has the trigger low
  `UER_ASSERT(a_report_nonzero,
              out_valid_o && result_valid_o |->
                distance_cm_o != '0 && !led_on_o && !trigger_level_o,
              "bad report")

  // no report means a zero distance field
  `UER_ASSERT(a_idle_zero, out_valid_o && !result_valid_o |-> distance_cm_o == '0,
              "distance without report")

  // a stalled result holds
  `UER_ASSERT(a_stall_hold,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_cm_o) &&
                $stable(result_valid_o) && $stable(led_on_o) && $stable(trigger_level_o),
              "stalled result changed")

  // register writes are never held off
  `UER_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "config not ready")

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);

`default_nettype wire
